FILE: rtl/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared widths, reset values and configuration type of the brightness
// change detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

   localparam int BRIGHT_W                 = 16;
   localparam int STREAK_W                 = 4;
   localparam int PERIOD_W                 = 16;
   localparam int DEFAULT_FRAME_INDEX_BITS = 20;

   localparam logic [BRIGHT_W-1:0] TOLERANCE_RESET     = 16'd1792;
   localparam logic [STREAK_W-1:0] STREAK_LENGTH_RESET = 4'd5;
   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET    = 16'd100;

   typedef struct packed {
      logic [BRIGHT_W-1:0] tolerance;
      logic [STREAK_W-1:0] streak_length;
      logic [PERIOD_W-1:0] min_period;
   } cfg_type;

endpackage

FILE: rtl/brightness_change_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brightness_change_detector_unit
// Day/night breakpoint detector driven by per-frame mean brightness.
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one request per video frame: mean brightness (8.8)
//   and frame index. rsp channel returns one result per request: breakpoint
//   flag, breakpoint frame, day/night label and current streak count.
//   csr port holds tolerance, streak length and minimum period; write it
//   only while no request is in flight.
// path: a request accepted at an edge is held in the input register and
//   its result is loaded into the result register once that register is
//   empty or being read; rsp_tvalid follows the result register.
// throughput: one request per cycle unless rsp_tready stalls it; the
//   state update is one subtract, compare and counter step between registers.
// reset: clears both valid flags, loads the default configuration, clears the
//   reference and streak and starts in the night period.
// stall: while rsp_tready is low the result holds, the input register keeps
//   one more request and req_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module brightness_change_detector_unit #(
   parameter int FRAME_INDEX_BITS = bcd_pkg::DEFAULT_FRAME_INDEX_BITS,
   localparam int REQ_W = ((bcd_pkg::BRIGHT_W + FRAME_INDEX_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((FRAME_INDEX_BITS + 2 + bcd_pkg::STREAK_W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // brightness, frame_index
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // breakpoint_found, breakpoint_frame, is_night, streak_count
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bcd_pkg::*;

   localparam logic [1:0] REG_TOLERANCE     = 2'd0;
   localparam logic [1:0] REG_STREAK_LENGTH = 2'd1;
   localparam logic [1:0] REG_MIN_PERIOD    = 2'd2;

   cfg_type                     cfg_ff;
   logic                        csr_write;

   logic                        in_valid_ff;
   logic [BRIGHT_W-1:0]         in_bright_ff;
   logic [FRAME_INDEX_BITS-1:0] in_frame_ff;
   logic                        out_valid_ff;
   logic                        advance;

   logic                        found;
   logic [FRAME_INDEX_BITS-1:0] bp_frame;
   logic                        night;
   logic [STREAK_W-1:0]         streak;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance     <= TOLERANCE_RESET;
         cfg_ff.streak_length <= STREAK_LENGTH_RESET;
         cfg_ff.min_period    <= MIN_PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_TOLERANCE:     cfg_ff.tolerance     <= csr_pwdata[BRIGHT_W-1:0];
            REG_STREAK_LENGTH: cfg_ff.streak_length <= csr_pwdata[STREAK_W-1:0];
            REG_MIN_PERIOD:    cfg_ff.min_period    <= csr_pwdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_TOLERANCE:     csr_prdata = 32'(cfg_ff.tolerance);
         REG_STREAK_LENGTH: csr_prdata = 32'(cfg_ff.streak_length);
         REG_MIN_PERIOD:    csr_prdata = 32'(cfg_ff.min_period);
         default:           csr_prdata = '0;
      endcase
   end

   // request register, then result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_bright_ff <= req_tdata[BRIGHT_W-1:0];
         in_frame_ff  <= req_tdata[BRIGHT_W +: FRAME_INDEX_BITS];
      end
   end

   bcd_core #(
      .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .brightness       (in_bright_ff),
      .frame_index      (in_frame_ff),
      .cfg              (cfg_ff),
      .breakpoint_found (found),
      .breakpoint_frame (bp_frame),
      .is_night         (night),
      .streak_count     (streak)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({streak, night, bp_frame, found});

endmodule

FILE: rtl/bcd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_core
// Reference tracking, streak counting and breakpoint decision; holds the
// detector state and the result register.
// ----------------------------------------------------------------------------
module bcd_core #(
   parameter int FRAME_INDEX_BITS = bcd_pkg::DEFAULT_FRAME_INDEX_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [bcd_pkg::BRIGHT_W-1:0]   brightness,
   input  logic [FRAME_INDEX_BITS-1:0]    frame_index,
   input  bcd_pkg::cfg_type               cfg,
   output logic                           breakpoint_found,
   output logic [FRAME_INDEX_BITS-1:0]    breakpoint_frame,
   output logic                           is_night,
   output logic [bcd_pkg::STREAK_W-1:0]   streak_count
);
   import bcd_pkg::*;

   localparam int CMP_W = (FRAME_INDEX_BITS > PERIOD_W) ? FRAME_INDEX_BITS : PERIOD_W;

   logic [BRIGHT_W-1:0]         ref_bright_ff, ref_bright_in;
   logic [FRAME_INDEX_BITS-1:0] ref_frame_ff, ref_frame_in;
   logic [STREAK_W-1:0]         streak_ff, streak_in;
   logic [FRAME_INDEX_BITS-1:0] last_bp_ff, last_bp_in;
   logic                        night_ff, night_in;

   logic                        found_ff, found_in;
   logic [FRAME_INDEX_BITS-1:0] bp_frame_ff, bp_frame_in;
   logic                        night_out_ff;
   logic [STREAK_W-1:0]         streak_out_ff;

   logic [BRIGHT_W-1:0]         bright_diff;
   logic [FRAME_INDEX_BITS-1:0] frame_dist;
   logic [CMP_W-1:0]            dist_ext;
   logic [CMP_W-1:0]            period_ext;
   logic [FRAME_INDEX_BITS-1:0] ref_frame_mid;
   logic [STREAK_W-1:0]         streak_mid;

   always_comb begin
      bright_diff = (brightness >= ref_bright_ff) ? (brightness - ref_bright_ff)
                                                  : (ref_bright_ff - brightness);
      frame_dist  = (frame_index >= last_bp_ff) ? (frame_index - last_bp_ff)
                                                : (last_bp_ff - frame_index);
      dist_ext    = CMP_W'(frame_dist);
      period_ext  = CMP_W'(cfg.min_period);

      ref_bright_in = ref_bright_ff;
      ref_frame_in  = ref_frame_ff;
      streak_in     = streak_ff;
      last_bp_in    = last_bp_ff;
      night_in      = night_ff;
      found_in      = 1'b0;
      bp_frame_in   = '0;
      ref_frame_mid = ref_frame_ff;
      streak_mid    = streak_ff;

      if (frame_index == '0) begin
         ref_bright_in = brightness;
         ref_frame_in  = '0;
         streak_in     = '0;
         last_bp_in    = '0;
         found_in      = 1'b1;
      end else begin
         if (bright_diff > cfg.tolerance) begin
            streak_mid = streak_ff + STREAK_W'(1);
         end else begin
            ref_bright_in = brightness;
            ref_frame_mid = frame_index;
            streak_mid    = '0;
         end
         ref_frame_in = ref_frame_mid;
         streak_in    = streak_mid;
         if (streak_mid == cfg.streak_length) begin
            if (dist_ext > period_ext) begin
               bp_frame_in = ref_frame_mid + FRAME_INDEX_BITS'(1);
               last_bp_in  = ref_frame_mid + FRAME_INDEX_BITS'(1);
               night_in    = ~night_ff;
               found_in    = 1'b1;
            end
            ref_bright_in = brightness;
            ref_frame_in  = frame_index;
            streak_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_bright_ff <= '0;
         ref_frame_ff  <= '0;
         streak_ff     <= '0;
         last_bp_ff    <= '0;
         night_ff      <= 1'b1;
      end else if (step) begin
         ref_bright_ff <= ref_bright_in;
         ref_frame_ff  <= ref_frame_in;
         streak_ff     <= streak_in;
         last_bp_ff    <= last_bp_in;
         night_ff      <= night_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         found_ff      <= found_in;
         bp_frame_ff   <= bp_frame_in;
         night_out_ff  <= night_in;
         streak_out_ff <= streak_in;
      end
   end

   assign breakpoint_found = found_ff;
   assign breakpoint_frame = bp_frame_ff;
   assign is_night         = night_out_ff;
   assign streak_count     = streak_out_ff;

`ifndef SYNTHESIS
   a_frame_zero_breakpoint: assert property (@(posedge clock) disable iff (reset)
      (step && frame_index == '0) |=> (found_ff && bp_frame_ff == '0 && streak_out_ff == '0))
      else $error("frame zero did not report a breakpoint at frame zero");

   a_toggle_on_breakpoint: assert property (@(posedge clock) disable iff (reset)
      (step && frame_index != '0) |=> (found_ff == (night_ff != $past(night_ff))))
      else $error("day/night flag toggle does not match breakpoint");

   a_no_frame_without_found: assert property (@(posedge clock) disable iff (reset)
      $past(step) && !found_ff |-> bp_frame_ff == '0)
      else $error("breakpoint frame set without a breakpoint");

   a_output_tracks_state: assert property (@(posedge clock) disable iff (reset)
      step |=> (night_out_ff == night_ff && streak_out_ff == streak_ff))
      else $error("result register disagrees with detector state");
`endif

endmodule

FILE: verif/tb_brightness_change_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brightness_change_detector_unit
// Self-checking bench for the day/night brightness change detector. A short
// table of frames covers frame zero, tolerance edges, confirmed and rejected
// changes and frame index wrap. Random scenes follow under six register
// settings: stable runs, brightness steps held long enough to confirm,
// broken steps, restarts and noise. A local model of the detector predicts
// each result the table leaves open; a scoreboard checks every result. Both
// stream sides idle at random, and the result side holds off once for a
// long stretch.
// ----------------------------------------------------------------------------
module tb_brightness_change_detector_unit;

   localparam int FRAME_W  = bcd_pkg::DEFAULT_FRAME_INDEX_BITS;
   localparam int BRIGHT_W = bcd_pkg::BRIGHT_W;
   localparam int STREAK_W = bcd_pkg::STREAK_W;
   localparam int REQ_BITS = ((BRIGHT_W + FRAME_W + 7) / 8) * 8;
   localparam int RSP_BITS = ((FRAME_W + 2 + STREAK_W + 7) / 8) * 8;

   localparam logic [3:0] TOLERANCE_ADDR     = 4'h0;
   localparam logic [3:0] STREAK_LENGTH_ADDR = 4'h4;
   localparam logic [3:0] MIN_PERIOD_ADDR    = 4'h8;

   localparam int SCENE_REQUESTS = 115;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef struct packed {
      logic                found;
      logic [FRAME_W-1:0]  bp_frame;
      logic                night;
      logic [STREAK_W-1:0] streak;
   } detection_type;

   typedef struct {
      logic [BRIGHT_W-1:0] level;
      logic [FRAME_W-1:0]  frame;
      bit                  typed;
      detection_type       outcome;
   } frame_row_type;

   logic                clock;
   logic                reset;
   logic [REQ_BITS-1:0] req_tdata;
   logic                req_tvalid;
   logic                req_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [3:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   bcd_pkg::cfg_type    active_cfg;
   logic [BRIGHT_W-1:0] anchor_level;
   logic [FRAME_W-1:0]  anchor_frame;
   logic [STREAK_W-1:0] change_run;
   logic [FRAME_W-1:0]  last_break;
   logic                night_period;

   detection_type       pending_detections[$];
   int                  mismatch_count;
   int                  detections_seen;
   int                  requests_sent;
   int                  steady_left;
   logic [FRAME_W-1:0]  frame_cursor;
   logic [BRIGHT_W-1:0] scene_level;

   brightness_change_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),   // brightness, frame_index
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),   // breakpoint_found, breakpoint_frame, is_night, streak_count
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic detection_type predict_detection(input logic [BRIGHT_W-1:0] level,
                                                       input logic [FRAME_W-1:0] frame);
      detection_type       res;
      logic [BRIGHT_W-1:0] gap;
      logic [FRAME_W-1:0]  spread;
      res = '0;
      if (frame == '0) begin
         anchor_level = level;
         anchor_frame = '0;
         change_run   = '0;
         last_break   = '0;
         res.found    = 1'b1;
      end else begin
         gap = (level >= anchor_level) ? level - anchor_level : anchor_level - level;
         if (gap > active_cfg.tolerance) begin
            change_run = change_run + 1'b1;
         end else begin
            anchor_level = level;
            anchor_frame = frame;
            change_run   = '0;
         end
         if (change_run == active_cfg.streak_length) begin
            spread = (frame >= last_break) ? frame - last_break : last_break - frame;
            if (spread > FRAME_W'(active_cfg.min_period)) begin
               res.bp_frame = anchor_frame + 1'b1;
               last_break   = res.bp_frame;
               night_period = ~night_period;
               res.found    = 1'b1;
            end
            anchor_level = level;
            anchor_frame = frame;
            change_run   = '0;
         end
      end
      res.night  = night_period;
      res.streak = change_run;
      return res;
   endfunction

   function automatic logic [BRIGHT_W-1:0] clamp_level(input int value);
      if (value < 0) return '0;
      if (value > 65535) return '1;
      return value[BRIGHT_W-1:0];
   endfunction

   // small wander that stays inside the tolerance
   function automatic logic [BRIGHT_W-1:0] near_level(input logic [BRIGHT_W-1:0] level);
      int span;
      span = (active_cfg.tolerance < 256) ? int'(active_cfg.tolerance) : 256;
      return clamp_level(int'(level) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic int sender_gap();
      int r;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         steady_left = $urandom_range(10, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_frame(input logic [BRIGHT_W-1:0] level, input logic [FRAME_W-1:0] frame,
                             input bit typed, input detection_type outcome);
      int            idle;
      detection_type predicted;
      idle = sender_gap();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tdata  <= REQ_BITS'({frame, level});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_detection(level, frame);
      pending_detections = {pending_detections, (typed ? outcome : predicted)};
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [BRIGHT_W-1:0] level, input logic [FRAME_W-1:0] frame);
      send_frame(level, frame, 1'b0, '0);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_detections.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] tolerance, input logic [3:0] streak_length,
                                 input logic [15:0] min_period);
      wait_drained();
      csr_write(TOLERANCE_ADDR, 32'(tolerance));
      csr_write(STREAK_LENGTH_ADDR, 32'(streak_length));
      csr_write(MIN_PERIOD_ADDR, 32'(min_period));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      active_cfg.tolerance     = tolerance;
      active_cfg.streak_length = streak_length;
      active_cfg.min_period    = min_period;
      @(negedge clock);
   endtask

   task automatic run_scenes(input int target);
      int                  stop_at;
      int                  kind;
      int                  hold;
      int                  count;
      int                  offset;
      logic [BRIGHT_W-1:0] stepped;
      stop_at = requests_sent + target;
      while (requests_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            // restart at frame zero
            scene_level = BRIGHT_W'($urandom);
            frame_cursor = '0;
            send_plain(scene_level, frame_cursor);
         end else if (kind < 22) begin
            send_plain(BRIGHT_W'($urandom), FRAME_W'($urandom));
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               frame_cursor = frame_cursor - FRAME_W'($urandom_range(1, 400));
            end else if ($urandom_range(0, 4) == 0) begin
               frame_cursor = FRAME_W'($urandom);
            end else begin
               frame_cursor = frame_cursor
                            + FRAME_W'($urandom_range(1, 3 * active_cfg.min_period + 2));
            end
            count = $urandom_range(1, 6);
            repeat (count) begin
               frame_cursor = frame_cursor + 1'b1;
               send_plain(near_level(scene_level), frame_cursor);
            end
            offset = int'(active_cfg.tolerance) + 1 + int'($urandom_range(0, 16'h3000));
            if ($urandom_range(0, 1)) offset = -offset;
            if (int'(scene_level) + offset > 65535 || int'(scene_level) + offset < 0) begin
               offset = -offset;
            end
            stepped = clamp_level(int'(scene_level) + offset);
            hold = (active_cfg.streak_length == '0) ? 16 : int'(active_cfg.streak_length);
            // broken step falls back before it is confirmed
            if (kind < 34) begin
               count = (hold > 1) ? int'($urandom_range(1, hold - 1)) : 1;
            end else begin
               count = hold + int'($urandom_range(0, 2));
            end
            repeat (count) begin
               frame_cursor = frame_cursor + 1'b1;
               send_plain(near_level(stepped), frame_cursor);
            end
            if (kind >= 34) scene_level = stepped;
         end
      end
   endtask

   // result side: random ready pattern plus one long hold-off
   initial begin
      int  ready_left;
      int  stall_left;
      int  r;
      bit  held_once;
      ready_left = 0;
      stall_left = 0;
      held_once  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_once && detections_seen >= 100) begin
            held_once = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (ready_left > 0) begin
            rsp_tready <= 1'b1;
            ready_left--;
         end else begin
            rsp_tready <= 1'b1;
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
            r = $urandom_range(0, 99);
            if (r < 80) stall_left = $urandom_range(1, 3);
            else if (r < 95) stall_left = $urandom_range(4, 12);
            else stall_left = $urandom_range(20, 60);
         end
      end
   end

   always @(posedge clock) begin
      detection_type seen;
      detection_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.found    = rsp_tdata[0];
         seen.bp_frame = rsp_tdata[FRAME_W:1];
         seen.night    = rsp_tdata[FRAME_W+1];
         seen.streak   = rsp_tdata[FRAME_W+STREAK_W+1:FRAME_W+2];
         detections_seen++;
         if (pending_detections.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result: found %0d frame %0d night %0d streak %0d",
                     $time, seen.found, seen.bp_frame, seen.night, seen.streak);
         end else begin
            wanted = pending_detections.pop_front();
            if (seen !== wanted) begin
               mismatch_count++;
               $display("%0t result mismatch: expected found %0d frame %0d night %0d streak %0d",
                        $time, wanted.found, wanted.bp_frame, wanted.night, wanted.streak);
               $display("%0t                    actual found %0d frame %0d night %0d streak %0d",
                        $time, seen.found, seen.bp_frame, seen.night, seen.streak);
            end
         end
      end
   end

   initial begin
      frame_row_type opening_rows[20];
      int            i;
      opening_rows = '{
         // request before frame zero, same level as the reset reference
         '{16'h0000, 20'd5,      1'b1, '{1'b0, 20'd0, 1'b1, 4'd0}},
         // frame zero reloads the reference and reports a breakpoint at 0
         '{16'hFFFF, 20'd0,      1'b1, '{1'b1, 20'd0, 1'b1, 4'd0}},
         '{16'h0000, 20'd10,     1'b1, '{1'b0, 20'd0, 1'b1, 4'd1}},
         // streak confirmed far from the last breakpoint
         '{16'h0000, 20'd200,    1'b0, '0},
         '{16'h0000, 20'd201,    1'b0, '0},
         '{16'h0000, 20'd202,    1'b0, '0},
         '{16'h0000, 20'd203,    1'b0, '0},
         // difference equal to tolerance, then one above
         '{16'h0700, 20'd204,    1'b0, '0},
         '{16'h0E01, 20'd205,    1'b0, '0},
         // reference at the last frame index, breakpoint wraps to zero
         '{16'h0700, 20'hFFFFF,  1'b0, '0},
         '{16'hF000, 20'hFFFFE,  1'b0, '0},
         '{16'hF000, 20'hFFFFE,  1'b0, '0},
         '{16'hF000, 20'hFFFFE,  1'b0, '0},
         '{16'hF000, 20'hFFFFE,  1'b0, '0},
         '{16'hF000, 20'hFFFFE,  1'b0, '0},
         // out of order frames, confirmed inside the minimum period
         '{16'h0000, 20'd50,     1'b0, '0},
         '{16'h0000, 20'd51,     1'b0, '0},
         '{16'h0000, 20'd52,     1'b0, '0},
         '{16'h0000, 20'd53,     1'b0, '0},
         '{16'h0000, 20'd54,     1'b0, '0}
      };
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count  = 0;
      detections_seen = 0;
      requests_sent   = 0;
      steady_left     = 0;
      frame_cursor    = 20'd1;
      scene_level     = 16'h8000;
      active_cfg.tolerance     = bcd_pkg::TOLERANCE_RESET;
      active_cfg.streak_length = bcd_pkg::STREAK_LENGTH_RESET;
      active_cfg.min_period    = bcd_pkg::MIN_PERIOD_RESET;
      anchor_level = '0;
      anchor_frame = '0;
      change_run   = '0;
      last_break   = '0;
      night_period = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < 20; i++) begin
         send_frame(opening_rows[i].level, opening_rows[i].frame,
                    opening_rows[i].typed, opening_rows[i].outcome);
      end

      apply_settings(16'd1792, 4'd5, 16'd100);
      run_scenes(SCENE_REQUESTS);
      apply_settings(16'd0, 4'd1, 16'd0);
      run_scenes(SCENE_REQUESTS);
      apply_settings(16'hFFFF, 4'd15, 16'hFFFF);
      run_scenes(SCENE_REQUESTS);
      apply_settings(16'd512, 4'd15, 16'd1000);
      run_scenes(SCENE_REQUESTS);
      // build a streak of eight, then lower the length below it
      send_plain(16'h1000, '0);
      repeat (8) begin
         frame_cursor = frame_cursor + 1'b1;
         send_plain(16'h9000, frame_cursor);
      end
      apply_settings(16'd300, 4'd0, 16'd20);
      run_scenes(SCENE_REQUESTS);
      apply_settings(16'd1024, 4'd3, 16'd64);
      run_scenes(SCENE_REQUESTS);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
